@@ design/isu_pkg.sv @@
`timescale 1ns / 1ps

package isu_pkg;

  // lattice geometry: side is a power of two, site index is {row, col}
  localparam int SIDE_W    = 8;
  localparam int SIDE      = 1 << SIDE_W;
  localparam int ADDR_W    = 2 * SIDE_W;
  localparam int SITES     = SIDE * SIDE;

  // payload widths
  localparam int SITE_W    = 16;
  localparam int RND_W     = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 18;
  localparam int ENE_W     = 19;
  localparam int CNT_W     = 3;

  // totals after reset: all spins up, every bond satisfied
  localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SITES);
  localparam logic [ENE_W-1:0] ENE_RESET = ENE_W'(-2 * SITES);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEPT_DE4 = 2'd0,
    REG_ACCEPT_DE8 = 2'd1
  } isu_cfg_reg_t;

  // which site the spin memory reads
  typedef enum logic [2:0] {
    NB_SITE  = 3'd0,
    NB_WEST  = 3'd1,
    NB_EAST  = 3'd2,
    NB_NORTH = 3'd3,
    NB_SOUTH = 3'd4
  } isu_nb_sel_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        rd_en;
    isu_nb_sel_t rd_sel;
    logic        cap_spin;
    logic        cnt_en;
    logic        commit;
    logic        clr_wr;
  } isu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } isu_status_t;

endpackage

@@ design/isu_in_if.sv @@
`timescale 1ns / 1ps

interface isu_in_if import isu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] site_index;
  logic [RND_W-1:0]  random_fraction;

  modport source (output valid, output site_index, output random_fraction, input ready);
  modport sink (input valid, input site_index, input random_fraction, output ready);
endinterface

@@ design/isu_out_if.sv @@
`timescale 1ns / 1ps

interface isu_out_if import isu_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    flipped;
  logic                    spin_after;
  logic signed [MAG_W-1:0] magnetization;
  logic signed [ENE_W-1:0] total_energy;

  modport source (output valid, output flipped, output spin_after, output magnetization,
                  output total_energy, input ready);
  modport sink (input valid, input flipped, input spin_after, input magnetization,
                input total_energy, output ready);
endinterface

@@ design/isu_cfg_if.sv @@
`timescale 1ns / 1ps

interface isu_cfg_if import isu_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/isu_datapath.sv @@
`timescale 1ns / 1ps

module isu_datapath import isu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  isu_cmd_t                cmd,
  output isu_status_t             status,
  input  logic [SITE_W-1:0]       in_site_index,
  input  logic [RND_W-1:0]        in_random_fraction,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_flipped,
  output logic                    out_spin_after,
  output logic signed [MAG_W-1:0] out_magnetization,
  output logic signed [ENE_W-1:0] out_total_energy
);

  logic                    spin_mem [SITES];
  logic                    rd_data_r;
  logic [ADDR_W-1:0]       clr_cnt_r;
  logic [ADDR_W-1:0]       idx_r;
  logic [RND_W-1:0]        rnd_r;
  logic                    spin_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CFG_W-1:0]        thr_de4_r;
  logic [CFG_W-1:0]        thr_de8_r;
  logic signed [MAG_W-1:0] mag_r;
  logic signed [ENE_W-1:0] ene_r;
  logic                    out_valid_r;
  logic                    out_flipped_r;
  logic                    out_spin_r;
  logic signed [MAG_W-1:0] out_mag_r;
  logic signed [ENE_W-1:0] out_ene_r;

  logic [SIDE_W-1:0]       row;
  logic [SIDE_W-1:0]       col;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       mem_addr;
  logic                    mem_we;
  logic                    mem_wdata;
  logic                    match;
  logic [CNT_W-1:0]        cnt_sum;
  logic                    lt_de4;
  logic                    lt_de8;
  logic                    take;
  logic                    spin_nxt;
  logic signed [ENE_W-1:0] de;
  logic signed [MAG_W-1:0] mag_nxt;
  logic signed [ENE_W-1:0] ene_nxt;

  // neighbor addresses, periodic wrap falls out of the modular row/col fields
  assign row = idx_r[ADDR_W-1:SIDE_W];
  assign col = idx_r[SIDE_W-1:0];

  always_comb begin
    case (cmd.rd_sel)
      NB_SITE:  rd_addr = in_site_index[ADDR_W-1:0];
      NB_WEST:  rd_addr = {row, col - SIDE_W'(1)};
      NB_EAST:  rd_addr = {row, col + SIDE_W'(1)};
      NB_NORTH: rd_addr = {row - SIDE_W'(1), col};
      NB_SOUTH: rd_addr = {row + SIDE_W'(1), col};
      default:  rd_addr = idx_r;
    endcase
  end

  // single-port spin memory: clearing pass, write-back or neighbor read
  always_comb begin
    if (cmd.clr_wr) begin
      mem_addr  = clr_cnt_r;
      mem_we    = 1'b1;
      mem_wdata = 1'b1;
    end else if (cmd.commit) begin
      mem_addr  = idx_r;
      mem_we    = take;
      mem_wdata = spin_nxt;
    end else begin
      mem_addr  = rd_addr;
      mem_we    = 1'b0;
      mem_wdata = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      spin_mem[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= spin_mem[mem_addr];
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // acceptance thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_de4_r <= '0;
      thr_de8_r <= '0;
    end else if (cfg_we) begin
      case (isu_cfg_reg_t'(cfg_index))
        REG_ACCEPT_DE4: thr_de4_r <= cfg_data;
        REG_ACCEPT_DE8: thr_de8_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture, site spin and count of aligned neighbors
  assign match   = (rd_data_r == spin_r);
  assign cnt_sum = cnt_r + CNT_W'(match);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_site_index[ADDR_W-1:0];
      rnd_r <= in_random_fraction;
    end
    if (cmd.cap_spin) begin
      spin_r <= rd_data_r;
      cnt_r  <= '0;
    end else if (cmd.cnt_en) begin
      cnt_r <= cnt_sum;
    end
  end

  // k aligned neighbors gives dE = 4k - 8
  assign lt_de4   = ({1'b0, rnd_r} < thr_de4_r);
  assign lt_de8   = ({1'b0, rnd_r} < thr_de8_r);
  assign take     = (cnt_sum <= CNT_W'(2)) ||
                    ((cnt_sum == CNT_W'(3)) && lt_de4) ||
                    ((cnt_sum == CNT_W'(4)) && lt_de8);
  assign spin_nxt = take ? ~spin_r : spin_r;
  assign de       = ENE_W'({cnt_sum, 2'b00}) - ENE_W'(8);

  always_comb begin
    mag_nxt = mag_r;
    ene_nxt = ene_r;
    if (take) begin
      mag_nxt = spin_nxt ? mag_r + MAG_W'(2) : mag_r - MAG_W'(2);
      ene_nxt = ene_r + de;
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= MAG_RESET;
      ene_r <= ENE_RESET;
    end else if (cmd.commit) begin
      mag_r <= mag_nxt;
      ene_r <= ene_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_flipped_r <= take;
      out_spin_r    <= spin_nxt;
      out_mag_r     <= mag_nxt;
      out_ene_r     <= ene_nxt;
    end
  end

  assign status.clr_last = (clr_cnt_r == {ADDR_W{1'b1}});
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_flipped       = out_flipped_r;
  assign out_spin_after    = out_spin_r;
  assign out_magnetization = out_mag_r;
  assign out_total_energy  = out_ene_r;

endmodule

@@ design/isu_ctrl.sv @@
`timescale 1ns / 1ps

module isu_ctrl import isu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  isu_status_t status,
  output isu_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RD_W   = 7'b0000100,
    ST_RD_E   = 7'b0001000,
    ST_RD_N   = 7'b0010000,
    ST_RD_S   = 7'b0100000,
    ST_UPDATE = 7'b1000000
  } isu_state_t;

  isu_state_t state_r;
  isu_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one memory access per cycle: site, four neighbors, write-back once the output is free
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.rd_sel = NB_SITE;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.rd_en = 1'b1;
          state_nxt = ST_RD_W;
        end
      end
      ST_RD_W: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = NB_WEST;
        cmd.cap_spin = 1'b1;
        state_nxt    = ST_RD_E;
      end
      ST_RD_E: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NB_EAST;
        cmd.cnt_en = 1'b1;
        state_nxt  = ST_RD_N;
      end
      ST_RD_N: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NB_NORTH;
        cmd.cnt_en = 1'b1;
        state_nxt  = ST_RD_S;
      end
      ST_RD_S: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NB_SOUTH;
        cmd.cnt_en = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait here while the previous result is still held
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ design/ising_metropolis_site_update_top.sv @@
// a request passes IDLE, RD_W, RD_E, RD_N, RD_S and UPDATE, where the result is registered once the output is free
// one request at a time, set by the single-port spin memory
//   (site read, four neighbor reads, one write-back)
// reset: synchronous active low; a clearing pass over all 65536 sites sets every spin
//   to +1 with in ready low, thresholds reset to 0, totals to M = 65536, E = -131072
`timescale 1ns / 1ps

module ising_metropolis_site_update_top import isu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  isu_in_if.sink   in_ch,
  isu_out_if.source out_ch,
  isu_cfg_if.sink  cfg_ch
);

  isu_cmd_t    cmd;
  isu_status_t status;
  logic        in_ready;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  isu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  isu_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_site_index      (in_ch.site_index),
    .in_random_fraction (in_ch.random_fraction),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_flipped        (out_ch.flipped),
    .out_spin_after     (out_ch.spin_after),
    .out_magnetization  (out_ch.magnetization),
    .out_total_energy   (out_ch.total_energy)
  );

endmodule

@@ design/isu_checker.sv @@
`timescale 1ns / 1ps

module isu_checker import isu_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_flipped,
  input logic                    out_spin_after,
  input logic signed [MAG_W-1:0] out_magnetization,
  input logic signed [ENE_W-1:0] out_total_energy
);

  // no request taken right after reset while the spin memory is cleared
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_ready)
    else $error("request port ready right after reset");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request port ready in the cycle after a request");

  // held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flipped) &&
      $stable(out_spin_after) && $stable(out_magnetization) && $stable(out_total_energy))
    else $error("stalled result changed");

  // magnetization moves in steps of 2, energy in multiples of 4, from starting values that are multiples of 4
  a_total_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_magnetization[0] && (out_total_energy[1:0] == 2'b00))
    else $error("magnetization or energy off its lattice");

endmodule

bind ising_metropolis_site_update_top isu_checker u_isu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_flipped       (out_ch.flipped),
  .out_spin_after    (out_ch.spin_after),
  .out_magnetization (out_ch.magnetization),
  .out_total_energy  (out_ch.total_energy)
);

@@ bench/tb_ising_metropolis_site_update_top.sv @@
`timescale 1ns / 1ps

module tb_ising_metropolis_site_update_top;
  import isu_pkg::*;

  // a cleared lattice takes a full pass over the store before the first request
  localparam int WATCHDOG_LIMIT = 4 * SITES;
  localparam int TAIL_CYCLES    = 10;
  localparam logic [CFG_W-1:0] THR_ALWAYS = CFG_W'(1 << RND_W);
  localparam logic [CFG_W-1:0] THR_MAX    = '1;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic                    flipped;
    logic                    spin_after;
    logic signed [MAG_W-1:0] magnetization;
    logic signed [ENE_W-1:0] total_energy;
  } site_result_t;

  logic clk;
  logic rst_n;

  isu_in_if  in_ch();
  isu_out_if out_ch();
  isu_cfg_if cfg_ch();

  ising_metropolis_site_update_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // mirror of the lattice, the running totals and the thresholds
  bit                      spin_up [SITES];
  logic signed [MAG_W-1:0] magnet_sum;
  logic signed [ENE_W-1:0] energy_sum;
  logic [CFG_W-1:0]        thr_de4;
  logic [CFG_W-1:0]        thr_de8;

  site_result_t expected_updates[$];
  int           error_count    = 0;
  int           idle_cycles    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // spin of a lattice site as +1 / -1
  function automatic int spin_at(input logic [SIDE_W-1:0] row, input logic [SIDE_W-1:0] col);
    return spin_up[{row, col}] ? 1 : -1;
  endfunction

  // one metropolis step on the mirror, returns what the block should report
  function automatic site_result_t predict_site_update(input logic [SITE_W-1:0] site,
                                                       input logic [RND_W-1:0] rnd);
    logic [ADDR_W-1:0] idx;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    int                s;
    int                h;
    int                de;
    bit                take;
    site_result_t      res;
    idx = ADDR_W'(site % SITES);
    row = idx[ADDR_W-1 -: SIDE_W];
    col = idx[SIDE_W-1:0];
    s   = spin_up[idx] ? 1 : -1;
    // neighbors wrap around through the modular row and column arithmetic
    h   = spin_at(row, SIDE_W'(col - 1)) + spin_at(row, SIDE_W'(col + 1))
        + spin_at(SIDE_W'(row - 1), col) + spin_at(SIDE_W'(row + 1), col);
    de  = 2 * s * h;
    if (de <= 0) begin
      take = 1'b1;
    end else if (de == 4) begin
      take = (CFG_W'(rnd) < thr_de4);
    end else begin
      take = (CFG_W'(rnd) < thr_de8);
    end
    if (take) begin
      spin_up[idx] = !spin_up[idx];
      magnet_sum   = spin_up[idx] ? magnet_sum + MAG_W'(2) : magnet_sum - MAG_W'(2);
      energy_sum   = energy_sum + ENE_W'(de);
    end
    res.flipped       = take;
    res.spin_after    = spin_up[idx];
    res.magnetization = magnet_sum;
    res.total_energy  = energy_sum;
    return res;
  endfunction

  // one request; valid stays up so back-to-back requests need no gap
  task automatic send_site(input logic [SITE_W-1:0] site, input logic [RND_W-1:0] rnd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.site_index      <= site;
    in_ch.random_fraction <= rnd;
    do @(posedge clk); while (!in_ch.ready);
    expected_updates.insert(expected_updates.size(), predict_site_update(site, rnd));
  endtask

  // hold off new requests until every pending result is back
  task automatic wait_results_drained();
    while (expected_updates.size() != 0) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // both thresholds written back to back
  task automatic set_thresholds(input logic [CFG_W-1:0] de4, input logic [CFG_W-1:0] de8);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_ACCEPT_DE4;
    cfg_ch.data  <= de4;
    do @(posedge clk); while (!cfg_ch.ready);
    thr_de4 = de4;
    cfg_ch.index <= REG_ACCEPT_DE8;
    cfg_ch.data  <= de8;
    do @(posedge clk); while (!cfg_ch.ready);
    thr_de8 = de8;
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a small patch across the lattice corner so updates interact
  function automatic logic [SITE_W-1:0] pick_site();
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    if ($urandom_range(0, 3) == 0) begin
      return SITE_W'($urandom);
    end
    row = SIDE_W'(SIDE - 2 + $urandom_range(0, 5));
    col = SIDE_W'(SIDE - 2 + $urandom_range(0, 5));
    return SITE_W'({row, col});
  endfunction

  function automatic logic [RND_W-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return RND_W'($urandom);
      end
    endcase
  endfunction

  // aligned, anti-aligned, partly aligned and balanced neighborhoods
  task automatic test_energy_cases();
    wait_results_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_thresholds(THR_ALWAYS, THR_ALWAYS);
    send_site(0, 16'hffff);        // all neighbors up, uphill by eight
    send_site(0, 16'h0000);        // lone down spin, downhill by eight
    send_site(0, 16'h1234);
    send_site(1, 16'hffff);        // one neighbor down, uphill by four
    send_site(SIDE, 16'h0000);
    send_site(SIDE + 1, 16'h8000); // two neighbors down, no energy change
    send_site(1, 16'h8000);
    send_site(SIDE, 16'hffff);
  endtask

  // sites on the lattice border, neighbors wrap to the far side
  task automatic test_lattice_wrap();
    send_site(SIDE - 1, 16'h0000);
    send_site(SITES - SIDE, 16'hffff);
    send_site(SITES - 1, 16'h5555);
    send_site(SITES - 1, 16'haaaa);
    send_site(SIDE / 2, 16'h0001);
    send_site(SITES / 2, 16'hfffe);
  endtask

  // zero, boundary and saturating thresholds
  task automatic test_threshold_limits();
    wait_results_drained();
    set_thresholds('0, '0);
    send_site(SITES / 2 + 5, 16'h0000);   // zero threshold refuses the lowest fraction
    send_site(SIDE + 2, 16'h0000);
    wait_results_drained();
    set_thresholds(CFG_W'(1000), CFG_W'(1000));
    send_site(3 * SIDE + 7, 16'd1000);    // fraction equal to threshold is refused
    send_site(3 * SIDE + 7, 16'd999);
    send_site(3 * SIDE + 8, 16'd999);
    wait_results_drained();
    set_thresholds(CFG_W'(65535), CFG_W'(65535));
    send_site(5 * SIDE + 9, 16'hffff);
    send_site(5 * SIDE + 9, 16'hfffe);
    wait_results_drained();
    set_thresholds(THR_MAX, THR_MAX);
    send_site(7 * SIDE + 11, 16'hffff);   // threshold beyond full scale always accepts
  endtask

  // random traffic under one idling pattern, with a full drain every so often
  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                     input logic [CFG_W-1:0] de4,
                                     input logic [CFG_W-1:0] de8);
    wait_results_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_thresholds(de4, de8);
    for (int i = 0; i < items; i++) begin
      if (i != 0 && i % 60 == 0) begin
        wait_results_drained();
      end
      send_site(pick_site(), pick_fraction());
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.site_index      <= '0;
    in_ch.random_fraction <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_ACCEPT_DE4;
    cfg_ch.data           <= '0;
    foreach (spin_up[i]) spin_up[i] = 1'b1;
    magnet_sum = MAG_RESET;
    energy_sum = ENE_RESET;
    thr_de4    = '0;
    thr_de8    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_energy_cases();
    test_lattice_wrap();
    test_threshold_limits();
    test_random_traffic(280, 0, 0, THR_ALWAYS, THR_ALWAYS);
    test_random_traffic(280, 82, 0, CFG_W'($urandom_range(0, 65536)),
                        CFG_W'($urandom_range(0, 65536)));
    test_random_traffic(280, 0, 82, THR_MAX, '0);
    test_random_traffic(300, 14, 14, CFG_W'($urandom_range(0, 65536)),
                        CFG_W'($urandom_range(0, 65536)));

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result check against the oldest pending prediction, then next ready
  always @(posedge clk) begin
    site_result_t got;
    site_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.flipped, out_ch.spin_after, out_ch.magnetization, out_ch.total_energy};
      if (expected_updates.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("%0t: unexpected result flip=%0b spin=%0b M=%0d E=%0d", $time,
                   got.flipped, got.spin_after, got.magnetization, got.total_energy);
        end
        error_count++;
      end else begin
        want = expected_updates.pop_front();
        if (got !== want) begin
          if (error_count < MAX_REPORTS) begin
            $display("%0t: mismatch exp f=%0b s=%0b M=%0d E=%0d got f=%0b s=%0b M=%0d E=%0d",
                     $time, want.flipped, want.spin_after, want.magnetization,
                     want.total_energy, got.flipped, got.spin_after, got.magnetization,
                     got.total_energy);
          end
          error_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ ising_metropolis_site_update_top.f @@
design/isu_pkg.sv
design/isu_in_if.sv
design/isu_out_if.sv
design/isu_cfg_if.sv
design/isu_datapath.sv
design/isu_ctrl.sv
design/ising_metropolis_site_update_top.sv
design/isu_checker.sv
bench/tb_ising_metropolis_site_update_top.sv
